/* rtl/lkv_pkg.sv */
// shared constants, types and field layout for the lru key-value cache
// no dependencies; every other rtl file imports this package
package lkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;

    // slot index and recency rank share one width
    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // fill count must reach ENTRIES itself
    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    // capacity register width is fixed by the register map
    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    // stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_BITS  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int IN_USER_BITS  = 1;
    localparam int OUT_DATA_BITS = ((VALUE_BITS + KEY_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS = 2;

    // operation codes carried in the input tuser
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // bit positions in the output tuser
    localparam int USR_HIT   = 0;
    localparam int USR_EVICT = 1;

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [CNT_BITS-1:0]   t_cnt;

    typedef logic [ENTRIES-1:0][KEY_BITS-1:0]   t_key_arr;
    typedef logic [ENTRIES-1:0][VALUE_BITS-1:0] t_value_arr;
    typedef logic [ENTRIES-1:0][IDX_BITS-1:0]   t_rank_arr;

    // update plan from the lookup stage to the entry store
    typedef struct packed {
        logic   upd;          // state changes (get hit or any put)
        logic   put;          // key and value are written at slot
        logic   hit;
        logic   insert;       // new key into a free slot, fill grows
        logic   evict;
        t_idx   slot;
        t_idx   thr;          // entries ranked below this age by one
        t_value read_value;
        t_key   evicted_key;
    } t_plan;

endpackage

/* rtl/lkv_match.sv */
// parallel lookup: key compare on all entries, free slot, lru victim, update plan
// depends on lkv_pkg
module lkv_match (
    input  lkv_pkg::t_key_arr             i_key_arr,
    input  lkv_pkg::t_value_arr           i_value_arr,
    input  logic [lkv_pkg::ENTRIES-1:0]   i_valid,
    input  lkv_pkg::t_rank_arr            i_rank,
    input  lkv_pkg::t_cnt                 i_count,
    input  logic [lkv_pkg::CAP_BITS-1:0]  i_cap,
    input  logic                          i_kind,
    input  lkv_pkg::t_key                 i_key,
    output lkv_pkg::t_plan                o_plan
);
    import lkv_pkg::*;

    logic [ENTRIES-1:0] match;
    logic               hit;
    t_idx               hit_idx;
    t_idx               free_idx;
    t_idx               victim_idx;
    t_idx               oldest_rank;
    t_cnt               cap_eff;
    logic               has_free;
    logic               put;

    // clamp capacity into 1..ENTRIES
    always_comb begin
        if (i_cap == '0) begin
            cap_eff = t_cnt'(1);
        end else if (32'(i_cap) > 32'(ENTRIES)) begin
            cap_eff = t_cnt'(ENTRIES);
        end else begin
            cap_eff = t_cnt'(i_cap);
        end
    end

    assign put         = (i_kind == OP_PUT);
    assign has_free    = (i_count < cap_eff);
    assign oldest_rank = t_idx'(i_count - 1'b1);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = i_valid[i] && (i_key_arr[i] == i_key);
        end
    end
    assign hit = |match;

    // lowest matching slot, lowest free slot
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = t_idx'(i);
            end
            if (!i_valid[i]) begin
                free_idx = t_idx'(i);
            end
        end
    end

    // least recent valid entry, highest index on a tie
    always_comb begin
        victim_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_valid[i] && (i_rank[i] == oldest_rank)) begin
                victim_idx = t_idx'(i);
            end
        end
    end

    always_comb begin
        o_plan        = '0;
        o_plan.hit    = hit;
        o_plan.put    = put;
        o_plan.upd    = hit || put;
        o_plan.insert = !hit && put && has_free;
        o_plan.evict  = !hit && put && !has_free;
        if (hit) begin
            o_plan.slot = hit_idx;
            o_plan.thr  = i_rank[hit_idx];
        end else if (has_free) begin
            // new entry sits past every rank, so all valid entries age
            o_plan.slot = free_idx;
            o_plan.thr  = t_idx'(i_count);
        end else begin
            o_plan.slot = victim_idx;
            o_plan.thr  = i_rank[victim_idx];
        end
        if (hit && !put) begin
            o_plan.read_value = i_value_arr[hit_idx];
        end
        if (o_plan.evict) begin
            o_plan.evicted_key = i_key_arr[victim_idx];
        end
    end

endmodule

/* rtl/lkv_store.sv */
// entry store: keys, values, valid bits, recency ranks and fill count
// depends on lkv_pkg; applies one update plan per cycle while i_en is high
module lkv_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  lkv_pkg::t_plan                i_plan,
    input  lkv_pkg::t_key                 i_key,
    input  lkv_pkg::t_value               i_value,
    output lkv_pkg::t_key_arr             o_key_arr,
    output lkv_pkg::t_value_arr           o_value_arr,
    output logic [lkv_pkg::ENTRIES-1:0]   o_valid,
    output lkv_pkg::t_rank_arr            o_rank,
    output lkv_pkg::t_cnt                 o_count
);
    import lkv_pkg::*;

    t_key_arr           r_key;
    t_value_arr         r_value;
    logic [ENTRIES-1:0] r_valid;
    t_rank_arr          r_rank;
    t_cnt               r_count;

    // payload, no reset: read only behind a valid bit
    always_ff @(posedge i_clk) begin
        if (i_en && i_plan.put) begin
            r_key[i_plan.slot]   <= i_key;
            r_value[i_plan.slot] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rank  <= '0;
            r_count <= '0;
        end else if (i_en && i_plan.upd) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && (t_idx'(i) != i_plan.slot) && (r_rank[i] < i_plan.thr)) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
            r_rank[i_plan.slot]  <= '0;
            r_valid[i_plan.slot] <= 1'b1;
            if (i_plan.insert) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_key_arr   = r_key;
    assign o_value_arr = r_value;
    assign o_valid     = r_valid;
    assign o_rank      = r_rank;
    assign o_count     = r_count;

endmodule

/* rtl/lru_key_value_cache_core.sv */
// top level of the lru key-value cache: stream ports, capacity register,
// input and result registers; depends on lkv_pkg, lkv_match and lkv_store
//
// Fully associative key-value cache with 16 entries and least-recently-used
// replacement. Each input word is a get (tuser 0) or a put (tuser 1) with a
// key and, for puts, a value; each produces exactly one result word: hit flag,
// read value on a get hit, and the key of an entry evicted by a put of a new
// key. One word is accepted every cycle while the result side keeps up; each
// word passes through the input register, then the result register, and its
// result leaves when the result side takes it. The rate rests on the lookup
// and update of all entries: every key is compared in parallel and the
// recency ranks are rewritten in the same cycle, so the next word always sees
// the updated store. The store starts empty after reset with no clearing pass.
// Capacity (1..16, 0 reads as 1, larger values as 16) should only be written
// while no word is in flight; lowering it below the current fill drops nothing,
// later put misses then evict one for one.
module lru_key_value_cache_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // capacity write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lkv_pkg::CAP_BITS-1:0]       i_cfg_data,
    // request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lkv_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,   // key, write_value
    input  logic [lkv_pkg::IN_USER_BITS-1:0]   s_axis_tuser,   // kind
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [lkv_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,   // read_value, evicted_key
    output logic [lkv_pkg::OUT_USER_BITS-1:0]  m_axis_tuser    // hit, evicted
);
    import lkv_pkg::*;

    // capacity register, always ready
    logic [CAP_BITS-1:0] r_cap;

    // input register
    logic   r_in_valid;
    logic   r_in_kind;
    t_key   r_in_key;
    t_value r_in_value;

    // result register
    logic   r_out_valid;
    logic   r_out_hit;
    logic   r_out_evict;
    t_value r_out_read;
    t_key   r_out_evkey;

    // store view and plan
    t_key_arr           key_arr;
    t_value_arr         value_arr;
    logic [ENTRIES-1:0] valid;
    t_rank_arr          rank;
    t_cnt               count;
    t_plan              plan;

    logic advance;   // input register word moves into the result register
    logic s_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // the result register parts the two sides; the input register drains
    // whenever the result slot is free or being taken
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_kind  <= s_axis_tuser[0];
            r_in_key   <= s_axis_tdata[KEY_BITS-1:0];
            r_in_value <= s_axis_tdata[KEY_BITS +: VALUE_BITS];
        end
    end

    lkv_match u_match (
        .i_key_arr   (key_arr),
        .i_value_arr (value_arr),
        .i_valid     (valid),
        .i_rank      (rank),
        .i_count     (count),
        .i_cap       (r_cap),
        .i_kind      (r_in_kind),
        .i_key       (r_in_key),
        .o_plan      (plan)
    );

    // store updates in the same edge that captures the result
    lkv_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_plan      (plan),
        .i_key       (r_in_key),
        .i_value     (r_in_value),
        .o_key_arr   (key_arr),
        .o_value_arr (value_arr),
        .o_valid     (valid),
        .o_rank      (rank),
        .o_count     (count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_hit   <= plan.hit;
            r_out_evict <= plan.evict;
            r_out_read  <= plan.read_value;
            r_out_evkey <= plan.evicted_key;
        end
    end

    assign m_axis_tvalid           = r_out_valid;
    assign m_axis_tdata            = OUT_DATA_BITS'({r_out_evkey, r_out_read});
    assign m_axis_tuser[USR_HIT]   = r_out_hit;
    assign m_axis_tuser[USR_EVICT] = r_out_evict;

endmodule

/* rtl/lkv_checker.sv */
// port-level checks for the lru key-value cache, bound to the top level
// depends on lkv_pkg and lru_key_value_cache_core
module lkv_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [lkv_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input logic [lkv_pkg::OUT_USER_BITS-1:0]  m_axis_tuser
);
    import lkv_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // the request side never waits while the result side can take a word
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("request stalled with result side free");

    // a read value only comes with a hit
    a_read_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[USR_HIT] |-> (m_axis_tdata[VALUE_BITS-1:0] == '0))
        else $error("read value without hit");

    // eviction only on a miss, and its key is zero otherwise
    a_evict_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            !(m_axis_tuser[USR_EVICT] && m_axis_tuser[USR_HIT]) &&
            (m_axis_tuser[USR_EVICT] || (m_axis_tdata[VALUE_BITS +: KEY_BITS] == '0)))
        else $error("inconsistent eviction report");

endmodule

bind lru_key_value_cache_core lkv_checker u_lkv_checker (.*);

/* test/lkv_access_checker.sv */
// result checker for the lru key-value cache: watches the capacity, request and result channels
// keeps its own copy of the entry store and compares every result word with its prediction
// depends on lkv_pkg
module lkv_access_checker
    import lkv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CAP_BITS-1:0]      i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [IN_DATA_BITS-1:0]  i_in_data,    // key, write_value
    input  logic [IN_USER_BITS-1:0]  i_in_user,    // kind
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [OUT_DATA_BITS-1:0] i_out_data,   // read_value, evicted_key
    input  logic [OUT_USER_BITS-1:0] i_out_user,   // hit, evicted
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_hit_count,
    output int                       o_evict_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic   hit;
        t_value read_value;
        logic   evicted;
        t_key   evicted_key;
    } t_answer;

    // shadow copy of the entry store
    t_key               slot_key   [ENTRIES];
    t_value             slot_value [ENTRIES];
    logic               slot_live  [ENTRIES];
    int unsigned        slot_age   [ENTRIES];
    int unsigned        fill;
    logic [CAP_BITS-1:0] capacity_reg;

    t_answer answers_due[$];
    int fails     = 0;
    int depth     = 0;
    int hits      = 0;
    int evictions = 0;

    assign o_fail_count  = fails;
    assign o_pending     = depth;
    assign o_hit_count   = hits;
    assign o_evict_count = evictions;

    // slot s becomes newest, live entries newer than it age by one
    function automatic void make_newest(int s);
        int unsigned r;
        r = slot_age[s];
        for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && i != s && slot_age[i] < r)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    function automatic t_answer cache_access(logic kind, t_key key, t_value value);
        t_answer     ans;
        int unsigned limit;
        int unsigned oldest;
        int          found;
        int          slot;
        ans   = '0;
        limit = capacity_reg;
        if (limit == 0)
            limit = 1;
        if (limit > ENTRIES)
            limit = ENTRIES;
        found = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && slot_live[i] && slot_key[i] == key)
                found = i;
        if (found >= 0) begin
            ans.hit = 1'b1;
            make_newest(found);
            if (kind == OP_PUT)
                slot_value[found] = value;
            else
                ans.read_value = slot_value[found];
        end else if (kind == OP_PUT) begin
            slot = -1;
            if (fill < limit)
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !slot_live[i])
                        slot = i;
            if (slot >= 0) begin
                // new entry starts behind every rank so all live ones age
                slot_age[slot]  = fill;
                slot_live[slot] = 1'b1;
                make_newest(slot);
                fill++;
            end else begin
                oldest = 0;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_live[i] && (slot < 0 || slot_age[i] >= oldest)) begin
                        slot   = i;
                        oldest = slot_age[i];
                    end
                if (slot >= 0) begin
                    ans.evicted     = 1'b1;
                    ans.evicted_key = slot_key[slot];
                    make_newest(slot);
                end else begin
                    slot         = 0;
                    slot_age[0]  = 0;
                    slot_live[0] = 1'b1;
                    fill         = 1;
                end
            end
            slot_key[slot]   = key;
            slot_value[slot] = value;
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_live[i] = 1'b0;
                slot_age[i]  = 0;
            end
            fill         = 0;
            capacity_reg = CAP_RESET;
            answers_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                capacity_reg = i_cfg_data;
            // result first: a word leaving now never belongs to one arriving now
            if (i_out_valid && i_out_ready) begin
                got.hit         = i_out_user[USR_HIT];
                got.evicted     = i_out_user[USR_EVICT];
                got.read_value  = i_out_data[VALUE_BITS-1:0];
                got.evicted_key = i_out_data[VALUE_BITS +: KEY_BITS];
                if (answers_due.size() == 0) begin
                    $error("result word with no request waiting: hit %0d read_value %h",
                           got.hit, got.read_value);
                    fails++;
                end else begin
                    want = answers_due[0];
                    answers_due.delete(0);
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        fails++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h", want.read_value,
                               got.read_value);
                        fails++;
                    end
                    if (got.evicted !== want.evicted) begin
                        $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                        fails++;
                    end
                    if (got.evicted_key !== want.evicted_key) begin
                        $error("evicted_key: expected %h, got %h", want.evicted_key,
                               got.evicted_key);
                        fails++;
                    end
                    hits      += want.hit;
                    evictions += want.evicted;
                end
            end
            if (i_in_valid && i_in_ready)
                answers_due.insert(answers_due.size(),
                                   cache_access(i_in_user[0], i_in_data[KEY_BITS-1:0],
                                                i_in_data[KEY_BITS +: VALUE_BITS]));
        end
        depth = answers_due.size();
    end

endmodule

/* test/lru_key_value_cache_core_test.sv */
// top of the lru key-value cache testbench: clock, reset, request and capacity stimulus
// instantiates lru_key_value_cache_core and lkv_access_checker; depends on lkv_pkg
module lru_key_value_cache_core_test;
    import lkv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CAP_BITS-1:0]      i_cfg_data;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;    // key, write_value
    logic [IN_USER_BITS-1:0]  s_axis_tuser;    // kind
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;    // read_value, evicted_key
    logic [OUT_USER_BITS-1:0] m_axis_tuser;    // hit, evicted

    int fails;
    int pending;
    int hits;
    int evictions;

    // stimulus bookkeeping for the closing summary
    int gets       = 0;
    int puts       = 0;
    int cap_writes = 0;
    // when set, the request side sends back to back
    logic tx_calm  = 1'b1;

    lru_key_value_cache_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lkv_access_checker u_scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_user    (m_axis_tuser),
        .o_fail_count  (fails),
        .o_pending     (pending),
        .o_hit_count   (hits),
        .o_evict_count (evictions)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop, several times the slowest legal run
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    // result side back-pressure: short stalls mostly, a few long ones,
    // and stretches where tready stays high
    initial begin : result_ready
        int stall;
        int span;
        logic rx_calm;
        m_axis_tready = 1'b0;
        stall   = 0;
        span    = 0;
        rx_calm = 1'b0;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                rx_calm = ($urandom_range(0, 3) == 0);
                span    = $urandom_range(100, 400);
            end
            span--;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 99) < 20)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                        : $urandom_range(1, 3);
            end
        end
    end

    // one request word; called just after a falling edge, returns just after one
    task automatic request(input logic kind, input t_key key, input t_value value);
        int gap;
        int r;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= IN_DATA_BITS'({value, key});
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (kind == OP_GET)
            gets++;
        else
            puts++;
        // idle gap before the next word, mostly short
        gap = 0;
        if (!tx_calm) begin
            r   = $urandom_range(0, 99);
            gap = (r < 60) ? 0 :
                  (r < 85) ? $urandom_range(1, 2) :
                  (r < 96) ? $urandom_range(3, 6) : $urandom_range(10, 30);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // capacity is only written once every request has its result back
    task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cap_writes++;
    endtask

    initial begin : stimulus
        logic [CAP_BITS-1:0] cap_plan [10];
        t_key                key_pool [32];
        t_key                k;
        t_value              v;
        int                  cap_eff;
        int                  pool_n;
        int                  r;
        int                  guard;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_GET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, capacity at its reset value of 16
        request(OP_GET, 16'h0000, 32'h0000_0000);    // miss on the empty store
        request(OP_PUT, 16'h0000, 32'h0000_0000);
        request(OP_PUT, 16'hFFFF, 32'hFFFF_FFFF);
        request(OP_PUT, 16'h1234, 32'hA5A5_5A5A);
        request(OP_GET, 16'hFFFF, 32'h0000_0000);    // hit with all-ones value
        request(OP_GET, 16'h0000, 32'hFFFF_FFFF);    // hit with zero value
        request(OP_PUT, 16'h0000, 32'hDEAD_BEEF);    // update refreshes the entry
        request(OP_GET, 16'h0001, 32'h0000_0000);    // plain miss
        // capacity below the current fill of three: nothing dropped, misses swap
        set_capacity(5'd2);
        request(OP_PUT, 16'h0002, 32'h1111_1111);    // evicts 1234
        request(OP_PUT, 16'h0003, 32'h2222_2222);    // evicts ffff
        request(OP_GET, 16'h1234, 32'h0000_0000);
        // zero acts as one
        set_capacity(5'd0);
        request(OP_PUT, 16'h0004, 32'h3333_3333);
        request(OP_GET, 16'h0002, 32'h0000_0000);
        request(OP_GET, 16'h0003, 32'h0000_0000);
        // above the entry count acts as 16, free slots fill from the lowest index
        set_capacity(5'd31);
        request(OP_PUT, 16'h0005, 32'h4444_4444);
        request(OP_PUT, 16'h0006, 32'h5555_5555);
        request(OP_GET, 16'h0005, 32'h0000_0000);
        request(OP_PUT, 16'h0003, 32'h6666_6666);
        set_capacity(5'd1);
        request(OP_PUT, 16'h0007, 32'h7777_7777);
        request(OP_GET, 16'h0007, 32'h0000_0000);
        request(OP_GET, 16'h0000, 32'h0000_0000);

        // random phases, one capacity setting each, extremes included
        cap_plan[0] = 5'd1;
        cap_plan[1] = 5'd31;
        cap_plan[2] = 5'd0;
        cap_plan[3] = 5'd3;
        cap_plan[4] = 5'd16;
        cap_plan[5] = 5'd2;
        cap_plan[6] = CAP_BITS'($urandom_range(0, 31));
        cap_plan[7] = 5'd8;
        cap_plan[8] = CAP_BITS'($urandom_range(0, 31));
        cap_plan[9] = 5'd16;
        for (int p = 0; p < 10; p++) begin
            set_capacity(cap_plan[p]);
            cap_eff = (cap_plan[p] == 0) ? 1 : (cap_plan[p] > ENTRIES) ? ENTRIES : cap_plan[p];
            // a key pool a bit larger than the capacity gives both hits and evictions
            pool_n = cap_eff + $urandom_range(1, cap_eff / 2 + 3);
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int i = 2; i < pool_n; i++)
                key_pool[i] = t_key'($urandom);
            tx_calm = ($urandom_range(0, 3) == 0);
            repeat (65) begin
                k = ($urandom_range(0, 9) == 0) ? t_key'($urandom)
                                                : key_pool[$urandom_range(0, pool_n - 1)];
                r = $urandom_range(0, 15);
                v = (r == 0) ? '0 : (r == 1) ? '1 : t_value'($urandom);
                request(logic'($urandom_range(0, 1)), k, v);
            end
        end

        // drain: every result back, then let the two-stage pipe settle
        s_axis_tvalid <= 1'b0;
        for (guard = 0; guard < 5000 && pending != 0; guard++)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
        if (pending != 0)
            $error("%0d result words never arrived", pending);
        $display("sent %0d gets and %0d puts across %0d capacity writes", gets, puts,
                 cap_writes);
        $display("results checked included %0d hits and %0d evictions", hits, evictions);
        if (fails == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
rtl/lkv_pkg.sv
rtl/lkv_match.sv
rtl/lkv_store.sv
rtl/lru_key_value_cache_core.sv
rtl/lkv_checker.sv
test/lkv_access_checker.sv
test/lru_key_value_cache_core_test.sv
